FILE: hdl/network_game_fermi_update_defines.svh
// Assertion macros for the network game update RTL.
`ifndef NETWORK_GAME_FERMI_UPDATE_DEFINES_SVH
`define NETWORK_GAME_FERMI_UPDATE_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define NFU_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nfu assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define NFU_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nfu assertion failed");

`else

`define NFU_ASSERT_NOW(name, ante, cons)
`define NFU_ASSERT_NEXT(name, ante, cons)

`endif

`endif

FILE: hdl/nfu_pkg.sv
// Types, codes and the Fermi threshold table for the network game update block.
package nfu_pkg;

    typedef struct packed {
        logic [1:0]  action;
        logic [9:0]  node;
        logic [3:0]  slot;
        logic [9:0]  value;
        logic [15:0] pick_draw;
        logic [15:0] accept_draw;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        adopted;
        logic        strategy;
        logic [10:0] cooperators;
    } result_t;

    localparam logic [1:0] ACT_SET_DEGREE    = 2'd0;
    localparam logic [1:0] ACT_SET_NEIGHBOUR = 2'd1;
    localparam logic [1:0] ACT_SET_STRATEGY  = 2'd2;
    localparam logic [1:0] ACT_UPDATE        = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_ISOLATED = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    localparam logic CFG_SUCKER     = 1'b0;
    localparam logic CFG_TEMPTATION = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_DECODE,
        S_PICK,
        S_NREAD,
        S_NLATCH,
        S_OLATCH,
        S_WALK_F,
        S_WALK_O,
        S_DIFF,
        S_SAT,
        S_DECIDE,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        ALU_HOLD,
        ALU_CLEAR,
        ALU_ADD,
        ALU_RSUB
    } alu_op_t;

    typedef struct packed {
        logic deg;
        logic strat;
        logic nb;
    } mem_we_t;

    localparam int DIFF_LIMIT = 160;
    localparam logic [63:0] ONE_FIX = 64'd1 << 20;
    localparam logic [63:0] EXP_TENTH = 64'd1158856;

    // Thresholds for |d| = 0..160; negative d uses 65536 - entry.
    typedef logic [15:0] fermi_rom_t [0:DIFF_LIMIT];

    // Shift-subtract quotient, only evaluated while building the table.
    function automatic logic [63:0] table_quotient(
        input logic [63:0] num,
        input logic [63:0] dvs
    );
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, dvs})
            begin
                r    = r - {1'b0, dvs};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic fermi_rom_t build_fermi_rom();
        fermi_rom_t  rom;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] pos;
        e = ONE_FIX;
        for (int k = 0; k <= DIFF_LIMIT; k++) begin
            den = ONE_FIX + e;
            pos = table_quotient((64'd1 << 36) + (den >> 1), den);
            rom[k] = (pos > 64'd65535) ? 16'hFFFF : pos[15:0];
            if (k < DIFF_LIMIT) begin
                e = (e * EXP_TENTH + (64'd1 << 19)) >> 20;
            end
        end
        return rom;
    endfunction

    localparam fermi_rom_t FERMI_ROM = build_fermi_rom();

endpackage

FILE: hdl/network_game_fermi_update.sv
// Top level: sequencer, configuration and result register of the network game update.
//
//  channel | direction | handshake              | beat
//  item    | in        | item_valid/item_stall  | action, node, slot, value, draws
//  result  | out       | result_valid/result_stall | status, adopted, strategy, cooperators
//  cfg     | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// Load items pass through fetch and decode to the result register; an update
// also picks and reads a neighbour and then runs the two neighbour-list walks,
// over the focal and neighbour degrees, through the neighbour and strategy memory read ports.
// After reset a clearing pass over all NODES entries zeroes degrees and strategies;
// item_stall stays high meanwhile. item_stall is high while an item is in work;
// a finished beat waits in the result register, a new item is taken meanwhile.
`include "network_game_fermi_update_defines.svh"

module network_game_fermi_update import nfu_pkg::*; #(
    parameter int NODES      = 1024,
    parameter int MAX_DEGREE = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int NODE_W  = $clog2(NODES);
    localparam int SLOT_W  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int DEG_W   = $clog2(MAX_DEGREE + 1);
    localparam int COUNT_W = $clog2(NODES + 1);
    localparam int SUM_W   = $clog2(MAX_DEGREE * 200 + 1) + 2;

    localparam logic [NODE_W-1:0]       CLR_LAST = NODE_W'(NODES - 1);
    localparam logic signed [SUM_W-1:0] LIM_POS  = SUM_W'(DIFF_LIMIT);
    localparam logic signed [SUM_W-1:0] LIM_NEG  = -LIM_POS;

    function automatic logic signed [9:0] pair_term(
        input logic              me,
        input logic              them,
        input logic signed [7:0] s,
        input logic [7:0]        t
    );
        logic signed [9:0] r;
        if (me && them)
        begin
            r = 10'sd100;
        end
        else if (me)
        begin
            r = {{2{s[7]}}, s};
        end
        else if (them)
        begin
            r = {2'b00, t};
        end
        else
        begin
            r = '0;
        end
        return r;
    endfunction

    state_t state_reg, state_next;

    item_t                   item_reg, item_next;
    logic [DEG_W-1:0]        deg_f_reg, deg_f_next;
    logic                    strat_f_reg, strat_f_next;
    logic [NODE_W-1:0]       other_reg, other_next;
    logic [DEG_W-1:0]        deg_o_reg, deg_o_next;
    logic                    strat_o_reg, strat_o_next;
    logic [SLOT_W-1:0]       idx_reg, idx_next;
    logic [DEG_W-1:0]        walk_cnt_reg, walk_cnt_next;
    logic                    p1_reg, p1_next;
    logic                    p2_reg, p2_next;
    logic signed [SUM_W-1:0] focal_sum_reg, focal_sum_next;
    logic [7:0]              abs_reg, abs_next;
    logic                    neg_reg, neg_next;
    logic [1:0]              status_reg, status_next;
    logic                    adopted_reg, adopted_next;
    logic                    strat_out_reg, strat_out_next;
    logic [COUNT_W-1:0]      coop_reg, coop_next;
    logic [NODE_W-1:0]       clr_reg, clr_next;
    logic signed [7:0]       sucker_reg;
    logic [7:0]              temptation_reg;
    logic                    result_valid_reg, result_valid_next;
    result_t                 result_reg, result_next;

    mem_we_t                        mem_we;
    logic [NODE_W-1:0]              deg_addr, strat_addr, nb_wdata, nb_rdata;
    logic [DEG_W-1:0]               deg_wdata, deg_rdata;
    logic                           strat_wdata, strat_rdata;
    logic [NODE_W+SLOT_W-1:0]       nb_addr;
    alu_op_t                        alu_op;
    logic signed [SUM_W-1:0]        alu_operand, alu_acc;

    logic [NODE_W-1:0]   node_addr;
    logic                node_ok;
    logic                decode_go;
    logic [NODE_W-1:0]   walk_node;
    logic [DEG_W-1:0]    walk_deg;
    logic                walk_strat;
    logic                walk_done;
    logic [16+DEG_W-1:0] pick_prod;
    logic [DEG_W-1:0]    pick_raw;
    logic signed [SUM_W-1:0] acc_neg;
    logic [15:0]         rom_pos;
    logic [16:0]         thr;
    logic                can_load;

    nfu_mem #(
        .NODES      (NODES),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_mem (
        .clk         (clk),
        .we          (mem_we),
        .deg_addr    (deg_addr),
        .deg_wdata   (deg_wdata),
        .deg_rdata   (deg_rdata),
        .strat_addr  (strat_addr),
        .strat_wdata (strat_wdata),
        .strat_rdata (strat_rdata),
        .nb_addr     (nb_addr),
        .nb_wdata    (nb_wdata),
        .nb_rdata    (nb_rdata)
    );

    nfu_alu #(
        .SUM_W (SUM_W)
    ) u_alu (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (alu_op),
        .operand (alu_operand),
        .acc     (alu_acc)
    );

    assign item_stall   = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign node_addr = NODE_W'(item_reg.node);
    assign node_ok   = (32'(item_reg.node) < NODES);
    assign decode_go = node_ok && (item_reg.action == ACT_UPDATE) && (deg_rdata != '0);

    assign walk_node  = (state_reg == S_WALK_O) ? other_reg : node_addr;
    assign walk_deg   = (state_reg == S_WALK_O) ? deg_o_reg : deg_f_reg;
    assign walk_strat = (state_reg == S_WALK_O) ? strat_o_reg : strat_f_reg;
    assign walk_done  = (walk_cnt_reg == walk_deg) && !p1_reg && !p2_reg;

    assign pick_prod = item_reg.pick_draw * deg_f_reg;
    assign pick_raw  = pick_prod[16 +: DEG_W];
    assign acc_neg   = -alu_acc;
    assign rom_pos   = FERMI_ROM[abs_reg];
    assign can_load  = !result_valid_reg || !result_stall;

    always_comb
    begin
        thr = neg_reg ? (17'h10000 - {1'b0, rom_pos}) : {1'b0, rom_pos};
        if (thr > 17'h0FFFF)
        begin
            thr = 17'h0FFFF;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:  if (clr_reg == CLR_LAST) state_next = S_IDLE;
            S_IDLE:   if (item_valid) state_next = S_FETCH;
            S_FETCH:  state_next = S_DECODE;
            S_DECODE: state_next = decode_go ? S_PICK : S_DONE;
            S_PICK:   state_next = S_NREAD;
            S_NREAD:  state_next = S_NLATCH;
            S_NLATCH: state_next = S_OLATCH;
            S_OLATCH: state_next = S_WALK_F;
            S_WALK_F: if (walk_done) state_next = S_WALK_O;
            S_WALK_O: if (walk_done) state_next = S_DIFF;
            S_DIFF:   state_next = S_SAT;
            S_SAT:    state_next = S_DECIDE;
            S_DECIDE: state_next = S_DONE;
            S_DONE:   if (can_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        mem_we         = '0;
        deg_addr       = '0;
        deg_wdata      = '0;
        strat_addr     = '0;
        strat_wdata    = 1'b0;
        nb_addr        = '0;
        nb_wdata       = '0;
        alu_op         = ALU_HOLD;
        alu_operand    = '0;
        item_next      = item_reg;
        deg_f_next     = deg_f_reg;
        strat_f_next   = strat_f_reg;
        other_next     = other_reg;
        deg_o_next     = deg_o_reg;
        strat_o_next   = strat_o_reg;
        idx_next       = idx_reg;
        walk_cnt_next  = walk_cnt_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        focal_sum_next = focal_sum_reg;
        abs_next       = abs_reg;
        neg_next       = neg_reg;
        status_next    = status_reg;
        adopted_next   = adopted_reg;
        strat_out_next = strat_out_reg;
        coop_next      = coop_reg;
        clr_next       = clr_reg;
        result_next    = result_reg;
        result_valid_next = result_valid_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we.deg   = 1'b1;
                mem_we.strat = 1'b1;
                deg_addr     = clr_reg;
                strat_addr   = clr_reg;
                clr_next     = clr_reg + NODE_W'(1);
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next = item;
                end
            end
            S_FETCH:
            begin
                deg_addr   = node_addr;
                strat_addr = node_addr;
            end
            S_DECODE:
            begin
                status_next    = ST_DONE;
                adopted_next   = 1'b0;
                strat_out_next = strat_rdata;
                deg_addr       = node_addr;
                strat_addr     = node_addr;
                nb_addr        = {node_addr, SLOT_W'(item_reg.slot)};
                if (!node_ok)
                begin
                    status_next    = ST_RANGE;
                    strat_out_next = 1'b0;
                end
                else
                begin
                    case (item_reg.action)
                        ACT_SET_DEGREE:
                        begin
                            if (32'(item_reg.value) > MAX_DEGREE)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                mem_we.deg = 1'b1;
                                deg_wdata  = DEG_W'(item_reg.value);
                            end
                        end
                        ACT_SET_NEIGHBOUR:
                        begin
                            if (32'(item_reg.slot) >= MAX_DEGREE ||
                                32'(item_reg.value) >= NODES)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                mem_we.nb = 1'b1;
                                nb_wdata  = NODE_W'(item_reg.value);
                            end
                        end
                        ACT_SET_STRATEGY:
                        begin
                            if (item_reg.value > 10'd1)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                mem_we.strat   = 1'b1;
                                strat_wdata    = item_reg.value[0];
                                strat_out_next = item_reg.value[0];
                                if (item_reg.value[0] && !strat_rdata)
                                begin
                                    coop_next = coop_reg + COUNT_W'(1);
                                end
                                else if (!item_reg.value[0] && strat_rdata)
                                begin
                                    coop_next = coop_reg - COUNT_W'(1);
                                end
                            end
                        end
                        ACT_UPDATE:
                        begin
                            if (deg_rdata == '0)
                            begin
                                status_next = ST_ISOLATED;
                            end
                            deg_f_next   = deg_rdata;
                            strat_f_next = strat_rdata;
                        end
                        default:
                        begin
                            status_next = ST_RANGE;
                        end
                    endcase
                end
            end
            S_PICK:
            begin
                if (32'(pick_raw) >= MAX_DEGREE)
                begin
                    idx_next = SLOT_W'(MAX_DEGREE - 1);
                end
                else
                begin
                    idx_next = pick_raw[SLOT_W-1:0];
                end
            end
            S_NREAD:
            begin
                nb_addr = {node_addr, idx_reg};
            end
            S_NLATCH:
            begin
                other_next = nb_rdata;
                deg_addr   = nb_rdata;
                strat_addr = nb_rdata;
            end
            S_OLATCH:
            begin
                deg_o_next    = deg_rdata;
                strat_o_next  = strat_rdata;
                alu_op        = ALU_CLEAR;
                walk_cnt_next = '0;
                p1_next       = 1'b0;
                p2_next       = 1'b0;
            end
            S_WALK_F, S_WALK_O:
            begin
                // three-deep walk: list read, strategy read, accumulate
                p1_next = 1'b0;
                if (walk_cnt_reg < walk_deg)
                begin
                    nb_addr       = {walk_node, walk_cnt_reg[SLOT_W-1:0]};
                    walk_cnt_next = walk_cnt_reg + DEG_W'(1);
                    p1_next       = 1'b1;
                end
                if (p1_reg)
                begin
                    strat_addr = nb_rdata;
                end
                p2_next = p1_reg;
                if (p2_reg)
                begin
                    alu_op      = ALU_ADD;
                    alu_operand = SUM_W'(pair_term(walk_strat, strat_rdata,
                                                   sucker_reg, temptation_reg));
                end
                if (walk_done && state_reg == S_WALK_F)
                begin
                    focal_sum_next = alu_acc;
                    alu_op         = ALU_CLEAR;
                    walk_cnt_next  = '0;
                end
            end
            S_DIFF:
            begin
                alu_op      = ALU_RSUB;
                alu_operand = focal_sum_reg;
            end
            S_SAT:
            begin
                if (alu_acc > LIM_POS)
                begin
                    abs_next = 8'(DIFF_LIMIT);
                    neg_next = 1'b0;
                end
                else if (alu_acc < LIM_NEG)
                begin
                    abs_next = 8'(DIFF_LIMIT);
                    neg_next = 1'b1;
                end
                else if (alu_acc < 0)
                begin
                    abs_next = acc_neg[7:0];
                    neg_next = 1'b1;
                end
                else
                begin
                    abs_next = alu_acc[7:0];
                    neg_next = 1'b0;
                end
            end
            S_DECIDE:
            begin
                strat_addr     = node_addr;
                strat_out_next = strat_f_reg;
                if ({1'b0, item_reg.accept_draw} < thr)
                begin
                    adopted_next   = 1'b1;
                    mem_we.strat   = 1'b1;
                    strat_wdata    = strat_o_reg;
                    strat_out_next = strat_o_reg;
                    if (strat_o_reg && !strat_f_reg)
                    begin
                        coop_next = coop_reg + COUNT_W'(1);
                    end
                    else if (!strat_o_reg && strat_f_reg)
                    begin
                        coop_next = coop_reg - COUNT_W'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (can_load)
                begin
                    result_next.status      = status_reg;
                    result_next.adopted     = adopted_reg;
                    result_next.strategy    = strat_out_reg;
                    result_next.cooperators = 11'(coop_reg);
                    result_valid_next       = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_reg          <= '0;
            coop_reg         <= '0;
            walk_cnt_reg     <= '0;
            p1_reg           <= 1'b0;
            p2_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            coop_reg         <= coop_next;
            walk_cnt_reg     <= walk_cnt_next;
            p1_reg           <= p1_next;
            p2_reg           <= p2_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        deg_f_reg     <= deg_f_next;
        strat_f_reg   <= strat_f_next;
        other_reg     <= other_next;
        deg_o_reg     <= deg_o_next;
        strat_o_reg   <= strat_o_next;
        idx_reg       <= idx_next;
        focal_sum_reg <= focal_sum_next;
        abs_reg       <= abs_next;
        neg_reg       <= neg_next;
        status_reg    <= status_next;
        adopted_reg   <= adopted_next;
        strat_out_reg <= strat_out_next;
        result_reg    <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sucker_reg     <= 8'sd0;
            temptation_reg <= 8'd150;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SUCKER:     sucker_reg     <= cfg_data;
                CFG_TEMPTATION: temptation_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    `NFU_ASSERT_NOW(a_coop_bound, 1'b1, 32'(coop_reg) <= NODES)
    `NFU_ASSERT_NOW(a_coop_src, coop_reg != $past(coop_reg), $past(state_reg) == S_DECODE || $past(state_reg) == S_DECIDE)
    `NFU_ASSERT_NOW(a_result_src, $rose(result_valid_reg), $past(state_reg) == S_DONE)
    `NFU_ASSERT_NOW(a_walk_bound, state_reg == S_WALK_F || state_reg == S_WALK_O, walk_cnt_reg <= walk_deg)
    `NFU_ASSERT_NEXT(a_adopt_ok, state_reg == S_DECIDE && adopted_next, status_reg == ST_DONE && item_reg.action == ACT_UPDATE)

endmodule

FILE: hdl/nfu_mem.sv
// Degree, strategy and neighbour memories with registered reads.
module nfu_mem import nfu_pkg::*; #(
    parameter int NODES      = 1024,
    parameter int MAX_DEGREE = 16
) (
    input  logic                                   clk,
    input  mem_we_t                                we,
    input  logic [$clog2(NODES)-1:0]               deg_addr,
    input  logic [$clog2(MAX_DEGREE+1)-1:0]        deg_wdata,
    output logic [$clog2(MAX_DEGREE+1)-1:0]        deg_rdata,
    input  logic [$clog2(NODES)-1:0]               strat_addr,
    input  logic                                   strat_wdata,
    output logic                                   strat_rdata,
    input  logic [$clog2(NODES)+((MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1)-1:0] nb_addr,
    input  logic [$clog2(NODES)-1:0]               nb_wdata,
    output logic [$clog2(NODES)-1:0]               nb_rdata
);

    localparam int NODE_W   = $clog2(NODES);
    localparam int SLOT_W   = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int DEG_W    = $clog2(MAX_DEGREE + 1);
    localparam int NB_DEPTH = NODES << SLOT_W;

    logic [DEG_W-1:0]  deg_mem [0:NODES-1];
    logic              strat_mem [0:NODES-1];
    logic [NODE_W-1:0] nb_mem [0:NB_DEPTH-1];

    logic [DEG_W-1:0]  deg_rdata_reg;
    logic              strat_rdata_reg;
    logic [NODE_W-1:0] nb_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we.deg)
        begin
            deg_mem[deg_addr] <= deg_wdata;
        end
        deg_rdata_reg <= deg_mem[deg_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we.strat)
        begin
            strat_mem[strat_addr] <= strat_wdata;
        end
        strat_rdata_reg <= strat_mem[strat_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we.nb)
        begin
            nb_mem[nb_addr] <= nb_wdata;
        end
        nb_rdata_reg <= nb_mem[nb_addr];
    end

    assign deg_rdata   = deg_rdata_reg;
    assign strat_rdata = strat_rdata_reg;
    assign nb_rdata    = nb_rdata_reg;

endmodule

FILE: hdl/nfu_alu.sv
// Shared payoff accumulator: clear, add and reverse subtract.
module nfu_alu import nfu_pkg::*; #(
    parameter int SUM_W = 13
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  alu_op_t                 op,
    input  logic signed [SUM_W-1:0] operand,
    output logic signed [SUM_W-1:0] acc
);

    logic signed [SUM_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] acc_next;

    always_comb
    begin
        case (op)
            ALU_HOLD:  acc_next = acc_reg;
            ALU_CLEAR: acc_next = '0;
            ALU_ADD:   acc_next = acc_reg + operand;
            ALU_RSUB:  acc_next = operand - acc_reg;
            default:   acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

FILE: test/network_game_fermi_update_check.sv
// Watches the item, result and config channels, predicts each result beat and compares it.
`timescale 1ns / 1ps

module network_game_fermi_update_check import nfu_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       item_stall,
    input  item_t      item,
    input  logic       result_valid,
    input  logic       result_stall,
    input  result_t    result,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    output int         failures,
    output int         outstanding
);

    localparam int NODE_COUNT = 1024;
    localparam int DEG_MAX    = 16;
    localparam int DIFF_SPAN  = 160;

    // Shadow of the network
    logic        coop_bit  [0:NODE_COUNT-1];
    logic [4:0]  degree_of [0:NODE_COUNT-1];
    logic [9:0]  peer_of   [0:NODE_COUNT-1][0:DEG_MAX-1];
    logic [10:0] coop_count;
    int          sucker_pay;
    int          temptation_pay;

    // Adoption threshold per payoff difference, index d + DIFF_SPAN
    logic [15:0] adopt_limit [0:2*DIFF_SPAN];

    result_t     outcome_q [$];
    result_t     want;

    initial
    begin
        longint unsigned e;
        longint unsigned den;
        longint unsigned pos;
        failures       = 0;
        outstanding    = 0;
        coop_count     = '0;
        sucker_pay     = 0;
        temptation_pay = 150;
        for (int n = 0; n < NODE_COUNT; n++)
        begin
            coop_bit[n]  = 1'b0;
            degree_of[n] = '0;
            for (int s = 0; s < DEG_MAX; s++)
                peer_of[n][s] = '0;
        end
        // logistic in 0.16 fixed point, exp(d/10) stepped in 44.20
        e = 64'd1 << 20;
        for (int k = 0; k <= DIFF_SPAN; k++)
        begin
            den = (64'd1 << 20) + e;
            pos = ((64'd1 << 36) + den / 2) / den;
            adopt_limit[DIFF_SPAN + k] = (pos > 65535) ? 16'hFFFF : 16'(pos);
            adopt_limit[DIFF_SPAN - k] = (65536 - pos > 65535) ? 16'hFFFF : 16'(65536 - pos);
            if (k < DIFF_SPAN)
                e = (e * 64'd1158856 + (64'd1 << 19)) >> 20;
        end
    end

    function automatic int pair_payoff(logic self_coop, logic peer_coop);
        if (self_coop && peer_coop)
            return 100;
        if (self_coop)
            return sucker_pay;
        if (peer_coop)
            return temptation_pay;
        return 0;
    endfunction

    function automatic int node_payoff(int unsigned n);
        int sum;
        sum = 0;
        for (int i = 0; i < int'(degree_of[n]); i++)
            sum += pair_payoff(coop_bit[n], coop_bit[peer_of[n][i]]);
        return sum;
    endfunction

    function automatic void take_strategy(int unsigned n, logic s);
        if (coop_bit[n] != s)
        begin
            if (s)
                coop_count = coop_count + 11'd1;
            else
                coop_count = coop_count - 11'd1;
            coop_bit[n] = s;
        end
    endfunction

    function automatic result_t apply_item(item_t it);
        result_t     r;
        int unsigned deg;
        int unsigned idx;
        int unsigned other;
        int          d;
        r = '0;
        r.status = ST_DONE;
        case (it.action)
            ACT_SET_DEGREE:
            begin
                if (it.value > DEG_MAX)
                    r.status = ST_RANGE;
                else
                    degree_of[it.node] = it.value[4:0];
            end
            ACT_SET_NEIGHBOUR:
            begin
                peer_of[it.node][it.slot] = it.value;
            end
            ACT_SET_STRATEGY:
            begin
                if (it.value > 1)
                    r.status = ST_RANGE;
                else
                    take_strategy(it.node, it.value[0]);
            end
            default:
            begin
                deg = degree_of[it.node];
                if (deg == 0)
                    r.status = ST_ISOLATED;
                else
                begin
                    idx = (it.pick_draw * deg) >> 16;
                    if (idx >= DEG_MAX)
                        idx = DEG_MAX - 1;
                    other = peer_of[it.node][idx];
                    d = node_payoff(it.node) - node_payoff(other);
                    if (d > DIFF_SPAN)
                        d = DIFF_SPAN;
                    if (d < -DIFF_SPAN)
                        d = -DIFF_SPAN;
                    if (it.accept_draw < adopt_limit[d + DIFF_SPAN])
                    begin
                        r.adopted = 1'b1;
                        take_strategy(it.node, coop_bit[other]);
                    end
                end
            end
        endcase
        r.strategy    = coop_bit[it.node];
        r.cooperators = coop_count;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SUCKER)
                    sucker_pay = $signed(cfg_data);
                else
                    temptation_pay = int'(cfg_data);
            end
            // result side first, so a beat arriving with no prior item is caught
            if (result_valid && !result_stall)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("result beat with no item outstanding");
                    failures++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, result.status);
                        failures++;
                    end
                    if (result.adopted !== want.adopted)
                    begin
                        $error("adopted: expected %0d, got %0d", want.adopted, result.adopted);
                        failures++;
                    end
                    if (result.strategy !== want.strategy)
                    begin
                        $error("strategy: expected %0d, got %0d",
                               want.strategy, result.strategy);
                        failures++;
                    end
                    if (result.cooperators !== want.cooperators)
                    begin
                        $error("cooperators: expected %0d, got %0d",
                               want.cooperators, result.cooperators);
                        failures++;
                    end
                end
            end
            if (item_valid && !item_stall)
                outcome_q.push_back(apply_item(item));
            outstanding <= outcome_q.size();
        end
    end

endmodule

FILE: test/network_game_fermi_update_test.sv
// Stimulus, clock, reset and verdict for the network game update block.
`timescale 1ns / 1ps

module network_game_fermi_update_test;
    import nfu_pkg::*;

    logic       clk;
    logic       rst_n        = 1'b0;
    logic       item_valid   = 1'b0;
    logic       item_stall;
    item_t      item         = '0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    result_t    result;
    logic       cfg_valid    = 1'b0;
    logic       cfg_ready;
    logic       cfg_index    = CFG_SUCKER;
    logic [7:0] cfg_data     = '0;

    int failures;
    int outstanding;
    int accepted   = 0;
    int returned   = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;

    // slots written so far per node; a degree is only raised over written slots
    logic [15:0] filled [0:1023];

    network_game_fermi_update dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    network_game_fermi_update_check game_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // receiver: free-flowing, choppy, or long held stretches
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 200);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 2) == 0);
            default: result_stall <= ($urandom_range(0, 15) == 0) ? ~result_stall : result_stall;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            returned <= returned + 1;
    end

    initial
    begin
        #15_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic item_t make_beat(logic [1:0] action, logic [9:0] node, logic [3:0] slot,
                                        logic [9:0] value, logic [15:0] pick,
                                        logic [15:0] accept);
        item_t it;
        it.action      = action;
        it.node        = node;
        it.slot        = slot;
        it.value       = value;
        it.pick_draw   = pick;
        it.accept_draw = accept;
        return it;
    endfunction

    function automatic int written_run(logic [15:0] m);
        int n;
        n = 0;
        while (n < 16 && m[n])
            n++;
        return n;
    endfunction

    // working set: low ids and ids near the top of the range
    function automatic logic [9:0] pool_node();
        int p;
        p = $urandom_range(0, 47);
        return 10'((p < 24) ? p : 1023 - (p - 24));
    endfunction

    function automatic logic [9:0] neighbour_id();
        return ($urandom_range(0, 6) == 0) ? 10'($urandom) : pool_node();
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        burst_left--;
        accepted++;
        if (it.action == ACT_SET_NEIGHBOUR)
            filled[it.node][it.slot] = 1'b1;
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        burst_left = 0;
        while (returned != accepted)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_payoffs(input int sucker, input int temptation);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SUCKER;
        cfg_data  <= 8'(sucker);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= CFG_TEMPTATION;
        cfg_data  <= 8'(temptation);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_traffic(input int count);
        int          start;
        int          roll;
        int          k;
        logic [9:0]  n;
        logic [15:0] acc;
        item_t       it;
        start = accepted;
        while (accepted - start < count)
        begin
            roll = $urandom_range(0, 99);
            n = ($urandom_range(0, 6) == 0) ? 10'($urandom) : pool_node();
            if (roll < 12)
            begin
                // wire up a node: fill its list, then set the degree over it
                k = ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(1, 15);
                for (int s = 0; s < k; s++)
                    send_item(make_beat(ACT_SET_NEIGHBOUR, n, 4'(s), neighbour_id(),
                                        16'($urandom), 16'($urandom)));
                send_item(make_beat(ACT_SET_DEGREE, n, 4'($urandom), 10'(k),
                                    16'($urandom), 16'($urandom)));
            end
            else if (roll < 50)
            begin
                acc = 16'($urandom);
                if ($urandom_range(0, 9) == 0)
                    acc = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                send_item(make_beat(ACT_UPDATE, n, 4'($urandom), 10'($urandom),
                                    16'($urandom), acc));
            end
            else if (roll < 65)
            begin
                send_item(make_beat(ACT_SET_STRATEGY, n, 4'($urandom),
                                    ($urandom_range(0, 6) == 0) ? 10'($urandom_range(2, 1023))
                                                                : 10'($urandom_range(0, 1)),
                                    16'($urandom), 16'($urandom)));
            end
            else if (roll < 80)
            begin
                send_item(make_beat(ACT_SET_NEIGHBOUR, n, 4'($urandom), neighbour_id(),
                                    16'($urandom), 16'($urandom)));
            end
            else if (roll < 92)
            begin
                send_item(make_beat(ACT_SET_DEGREE, n, 4'($urandom),
                                    ($urandom_range(0, 4) == 0)
                                        ? 10'($urandom_range(17, 1023))
                                        : 10'($urandom_range(0, written_run(filled[n]))),
                                    16'($urandom), 16'($urandom)));
            end
            else
            begin
                // noise beat; a degree is never raised past written slots
                it = item_t'(58'({$urandom, $urandom}));
                if (it.action == ACT_SET_DEGREE && it.value <= 16
                        && it.value > written_run(filled[it.node]))
                    it.value = 10'(written_run(filled[it.node]));
                send_item(it);
            end
        end
    endtask

    initial
    begin
        foreach (filled[i])
            filled[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       set_payoffs(-100, 200);
                1:       set_payoffs(100, 0);
                2:       set_payoffs(-1, 1);
                3:       set_payoffs(0, 150);
                default: set_payoffs($urandom_range(0, 200) - 100, $urandom_range(0, 200));
            endcase
            if (ph == 0)
            begin
                // isolated focal node, strategy and degree range errors, small network
                send_item(make_beat(ACT_UPDATE,        10'd0,    4'd0,  10'd0,    16'd0, 16'd0));
                send_item(make_beat(ACT_SET_STRATEGY,  10'd0,    4'd0,  10'd1,    16'd0, 16'd0));
                send_item(make_beat(ACT_SET_STRATEGY,  10'd1023, 4'd0,  10'd1,    16'd0, 16'd0));
                send_item(make_beat(ACT_SET_STRATEGY,  10'd1,    4'd0,  10'd0,    16'd0, 16'd0));
                send_item(make_beat(ACT_SET_STRATEGY,  10'd7,    4'd0,  10'd2,    16'd0, 16'd0));
                send_item(make_beat(ACT_SET_STRATEGY,  10'd7,    4'd0,  10'd1023, 16'd0, 16'd0));
                send_item(make_beat(ACT_SET_DEGREE,    10'd0,    4'd0,  10'd17,   16'd0, 16'd0));
                send_item(make_beat(ACT_SET_DEGREE,    10'd0,    4'd0,  10'd1023, 16'd0, 16'd0));
                send_item(make_beat(ACT_SET_NEIGHBOUR, 10'd0,    4'd0,  10'd1023, 16'd0, 16'd0));
                send_item(make_beat(ACT_SET_NEIGHBOUR, 10'd0,    4'd1,  10'd1,    16'd0, 16'd0));
                send_item(make_beat(ACT_SET_NEIGHBOUR, 10'd0,    4'd2,  10'd512,  16'd0, 16'd0));
                send_item(make_beat(ACT_SET_NEIGHBOUR, 10'd0,    4'd3,  10'd0,    16'd0, 16'd0));
                send_item(make_beat(ACT_SET_NEIGHBOUR, 10'd0,    4'd15, 10'd1023, 16'd0, 16'd0));
                send_item(make_beat(ACT_SET_DEGREE,    10'd0,    4'd0,  10'd4,    16'd0, 16'd0));
                send_item(make_beat(ACT_UPDATE,        10'd0,    4'd0,  10'd0,    16'd0, 16'd0));
                send_item(make_beat(ACT_UPDATE, 10'd0, 4'd15, 10'd1023, 16'hFFFF, 16'hFFFF));
                send_item(make_beat(ACT_UPDATE,        10'd0,    4'd0,  10'd0,  16'h8000, 16'd1));
                send_item(make_beat(ACT_UPDATE,        10'd1023, 4'd0,  10'd0,    16'd0, 16'd0));
            end
            random_traffic(250);
            drain();
        end
        if (failures == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
